@@ rtl/char_lcd_nibble_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_assert.svh
// Assertion macros used by the LCD sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// same-cycle implication, held off during reset
`define CLCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clcd check failed");

// next-cycle implication, held off during reset
`define CLCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clcd check failed");

`endif

@@ rtl/clcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, codes and the microcode table of the character LCD sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CHAR   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_POWER_UP  = 2'd0,
    CFG_INIT_PULS = 2'd1,
    CFG_PULSE     = 2'd2,
    CFG_CLEAR     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {RS_LATCH, RS_ZERO, RS_REQ} rs_src_t;
  typedef enum logic [1:0] {NIB_LATCH, NIB_CONST, NIB_HI, NIB_LO} nib_src_t;
  // HOLD_PULSE_X: pulse plus the clear wait when the request carries it
  typedef enum logic [1:0] {HOLD_POWER, HOLD_INIT, HOLD_PULSE, HOLD_PULSE_X} hold_src_t;
  typedef enum logic {SEQ_NEXT, SEQ_END} seq_t;

  typedef struct packed {
    rs_src_t   rs_src;
    logic      en;
    nib_src_t  nib_src;
    logic [3:0] nib_const;
    hold_src_t hold_src;
    seq_t      seq;
  } ctrl_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic [8:0] hold;
  } pin_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_INIT = 5'd0;
  localparam logic [PC_W-1:0] PC_BYTE = 5'd25;
  localparam logic [PC_W-1:0] PC_LAST = 5'd28;

  function automatic ctrl_t mk(rs_src_t rs, logic en, nib_src_t ns, logic [3:0] nc,
                               hold_src_t hs, seq_t sq);
    ctrl_t c;
    c.rs_src    = rs;
    c.en        = en;
    c.nib_src   = ns;
    c.nib_const = nc;
    c.hold_src  = hs;
    c.seq       = sq;
    return c;
  endfunction

  // microcode: init program at 0..24, generic byte routine at 25..28
  function automatic ctrl_t rom_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    w = mk(RS_ZERO, 1'b0, NIB_LATCH, 4'h0, HOLD_PULSE, SEQ_END);
    case (pc)
      5'd0:  w = mk(RS_LATCH, 1'b0, NIB_LATCH, 4'h0, HOLD_POWER, SEQ_NEXT);
      5'd1:  w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h3, HOLD_INIT, SEQ_NEXT);
      5'd2:  w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h3, HOLD_INIT, SEQ_NEXT);
      5'd3:  w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h3, HOLD_INIT, SEQ_NEXT);
      5'd4:  w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h3, HOLD_INIT, SEQ_NEXT);
      5'd5:  w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h3, HOLD_INIT, SEQ_NEXT);
      5'd6:  w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h3, HOLD_INIT, SEQ_NEXT);
      5'd7:  w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h2, HOLD_INIT, SEQ_NEXT);
      5'd8:  w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h2, HOLD_INIT, SEQ_NEXT);
      // function set 0x28
      5'd9:  w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h2, HOLD_PULSE, SEQ_NEXT);
      5'd10: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h2, HOLD_PULSE, SEQ_NEXT);
      5'd11: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h8, HOLD_PULSE, SEQ_NEXT);
      5'd12: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h8, HOLD_PULSE, SEQ_NEXT);
      // display on 0x0C
      5'd13: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd14: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd15: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'hC, HOLD_PULSE, SEQ_NEXT);
      5'd16: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'hC, HOLD_PULSE, SEQ_NEXT);
      // clear 0x01, extra wait on its last state
      5'd17: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd18: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd19: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h1, HOLD_PULSE, SEQ_NEXT);
      5'd20: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h1, HOLD_PULSE_X, SEQ_NEXT);
      // entry mode 0x06
      5'd21: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd22: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd23: w = mk(RS_ZERO, 1'b1, NIB_CONST, 4'h6, HOLD_PULSE, SEQ_NEXT);
      5'd24: w = mk(RS_ZERO, 1'b0, NIB_CONST, 4'h6, HOLD_PULSE, SEQ_END);
      // byte routine
      5'd25: w = mk(RS_REQ, 1'b1, NIB_HI, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd26: w = mk(RS_REQ, 1'b0, NIB_HI, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd27: w = mk(RS_REQ, 1'b1, NIB_LO, 4'h0, HOLD_PULSE, SEQ_NEXT);
      5'd28: w = mk(RS_REQ, 1'b0, NIB_LO, 4'h0, HOLD_PULSE_X, SEQ_END);
      default: w = mk(RS_ZERO, 1'b0, NIB_LATCH, 4'h0, HOLD_PULSE, SEQ_END);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/char_lcd_nibble_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// 4-bit character LCD sequencer: each request runs a microcode routine that
// produces a run of pin states (register select, enable, nibble, hold).
// ----------------------------------------------------------------------------
// The request is registered when taken; pin states are registered into m_tdata after it.
// Throughput: one pin state per cycle from the microcode step counter while the output
//   is not stalled; init runs the init program, byte requests the byte routine, one request in flight.
// Unknown commands are taken and produce nothing.
// Reset: idle, latches cleared, registers back to 50/5/1/2 ms.
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value[7:0], column[13:8], line_select[14], pad
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // enable_pin[0], nibble_pins[4:1], hold_ms[13:5], pad
  output logic        m_tuser,   // reg_select
  output logic        m_tlast
);
  import clcd_pkg::*;

  logic [7:0] power_up_wait_ms, init_pulse_ms, pulse_ms, clear_wait_ms;
  logic       busy;
  logic [PC_W-1:0] pc;
  logic       select_latch;
  logic [3:0] nibble_latch;
  logic       rs_req, add_clear;
  logic [7:0] byte_reg;
  logic       accept, adv;
  cmd_t       req_cmd;
  logic [7:0] cursor_addr;
  ctrl_t      ctrl;
  pin_t       pin;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign adv      = busy && (!m_tvalid || m_tready);
  assign req_cmd  = cmd_t'(s_tuser);
  assign cursor_addr = {1'b1, s_tdata[14], 6'd0} + {2'b00, s_tdata[13:8]};
  assign ctrl     = rom_word(pc);

  clcd_emit u_emit (
    .ctrl             (ctrl),
    .rs_req           (rs_req),
    .byte_reg         (byte_reg),
    .add_clear        (add_clear),
    .select_latch     (select_latch),
    .nibble_latch     (nibble_latch),
    .power_up_wait_ms (power_up_wait_ms),
    .init_pulse_ms    (init_pulse_ms),
    .pulse_ms         (pulse_ms),
    .clear_wait_ms    (clear_wait_ms),
    .pin              (pin)
  );

  // control state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_wait_ms <= 8'd50;
      init_pulse_ms    <= 8'd5;
      pulse_ms         <= 8'd1;
      clear_wait_ms    <= 8'd2;
      busy             <= 1'b0;
      pc               <= PC_INIT;
      m_tvalid         <= 1'b0;
      select_latch     <= 1'b0;
      nibble_latch     <= 4'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_POWER_UP:  power_up_wait_ms <= cfg_wdata;
          CFG_INIT_PULS: init_pulse_ms    <= cfg_wdata;
          CFG_PULSE:     pulse_ms         <= cfg_wdata;
          default:       clear_wait_ms    <= cfg_wdata;
        endcase
      end
      if (accept) begin
        priority case (req_cmd)
          CMD_INIT: begin
            busy <= 1'b1;
            pc   <= PC_INIT;
          end
          CMD_CHAR, CMD_WRITE, CMD_CURSOR, CMD_CLEAR: begin
            busy <= 1'b1;
            pc   <= PC_BYTE;
          end
          default: busy <= 1'b0;
        endcase
      end
      if (adv) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (adv) begin
        select_latch <= pin.rs;
        nibble_latch <= pin.nib;
        if (ctrl.seq == SEQ_END) busy <= 1'b0;
        else pc <= pc + 1'b1;
      end
    end
  end

  // request and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rs_req    <= (req_cmd == CMD_CHAR);
      add_clear <= (req_cmd == CMD_CLEAR) || (req_cmd == CMD_INIT);
      priority case (req_cmd)
        CMD_CURSOR: byte_reg <= cursor_addr;
        CMD_CLEAR:  byte_reg <= 8'h01;
        default:    byte_reg <= s_tdata[7:0];
      endcase
    end
    if (adv) begin
      m_tdata <= {2'b00, pin.hold, pin.nib, pin.en};
      m_tuser <= pin.rs;
      m_tlast <= (ctrl.seq == SEQ_END);
    end
  end

`include "char_lcd_nibble_sequencer_assert.svh"

  `CLCD_ASSERT_NOW(a_pc_range, clk, rst, busy, pc <= PC_LAST)
  `CLCD_ASSERT_NEXT(a_init_entry, clk, rst, accept && req_cmd == CMD_INIT, busy && pc == PC_INIT)
  `CLCD_ASSERT_NEXT(a_end_idles, clk, rst, adv && ctrl.seq == SEQ_END, !busy && m_tvalid && m_tlast)

endmodule

@@ rtl/clcd_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_emit
// Datapath: turns one control word into a pin state.
// ----------------------------------------------------------------------------
module clcd_emit (
  input  clcd_pkg::ctrl_t ctrl,
  input  logic            rs_req,
  input  logic [7:0]      byte_reg,
  input  logic            add_clear,
  input  logic            select_latch,
  input  logic [3:0]      nibble_latch,
  input  logic [7:0]      power_up_wait_ms,
  input  logic [7:0]      init_pulse_ms,
  input  logic [7:0]      pulse_ms,
  input  logic [7:0]      clear_wait_ms,
  output clcd_pkg::pin_t  pin
);
  import clcd_pkg::*;

  logic [7:0] extra;

  assign extra = add_clear ? clear_wait_ms : 8'd0;

  always_comb begin
    pin.en = ctrl.en;
    unique case (ctrl.rs_src)
      RS_LATCH: pin.rs = select_latch;
      RS_REQ:   pin.rs = rs_req;
      default:  pin.rs = 1'b0;
    endcase
    unique case (ctrl.nib_src)
      NIB_LATCH: pin.nib = nibble_latch;
      NIB_CONST: pin.nib = ctrl.nib_const;
      NIB_HI:    pin.nib = byte_reg[7:4];
      default:   pin.nib = byte_reg[3:0];
    endcase
    unique case (ctrl.hold_src)
      HOLD_POWER: pin.hold = {1'b0, power_up_wait_ms};
      HOLD_INIT:  pin.hold = {1'b0, init_pulse_ms};
      HOLD_PULSE: pin.hold = {1'b0, pulse_ms};
      default:    pin.hold = {1'b0, pulse_ms} + {1'b0, extra};
    endcase
  end

endmodule
